[rtl/solenoid_lock_controller_unit_assert.svh]
// Assertion macros shared by the solenoid lock controller RTL.
`ifndef SOLENOID_LOCK_CONTROLLER_UNIT_ASSERT_SVH
`define SOLENOID_LOCK_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SLC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define SLC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[rtl/slc_pkg.sv]
// Package with types and constants of the solenoid lock controller.
`default_nettype none

package slc_pkg;

  localparam int TIME_BITS = 16;

  localparam int unsigned RESET_COUNTDOWN  = 50;
  localparam int unsigned DEFAULT_ON_RESET = 50;
  localparam int unsigned DEBOUNCE_LIMIT   = 5;

  typedef logic [TIME_BITS-1:0] cnt_t;
  typedef logic [15:0]          time_t;
  typedef logic [1:0]           mode_t;
  typedef logic [4:0]           status_t;

  localparam mode_t MODE_TICK    = 2'd0;
  localparam mode_t MODE_OPEN    = 2'd1;
  localparam mode_t MODE_RELEASE = 2'd2;

  typedef struct packed {
    mode_t mode;
    logic  feedback;
    time_t on_time;
  } item_t;

  typedef struct packed {
    logic    drive;
    status_t status;
  } result_t;

endpackage

`default_nettype wire

[rtl/slc_if.sv]
// Handshake interfaces for the command item channel and the result channel.
`default_nettype none

interface slc_in_if;
  logic            valid;
  logic            ready;
  slc_pkg::mode_t  mode;
  logic            feedback;
  slc_pkg::time_t  on_time;

  modport source (output valid, output mode, output feedback, output on_time, input ready);
  modport sink   (input valid, input mode, input feedback, input on_time, output ready);
endinterface

interface slc_out_if;
  logic             valid;
  logic             ready;
  logic             drive;
  slc_pkg::status_t status;

  modport source (output valid, output drive, output status, input ready);
  modport sink   (input valid, input drive, input status, output ready);
endinterface

`default_nettype wire

[rtl/slc_core.sv]
// Lock state registers and the per-item next-state logic.
`default_nettype none
`include "solenoid_lock_controller_unit_assert.svh"

module slc_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            item_valid,
  input  wire slc_pkg::item_t  item,
  input  wire slc_pkg::time_t  default_on_time,
  output slc_pkg::result_t     result
);

  slc_pkg::cnt_t countdown_r, countdown_nxt;
  logic [2:0]    debounce_r, debounce_nxt;
  logic          pending_r, pending_nxt;
  logic          locked_r, locked_nxt;
  logic          opened_r, opened_nxt;
  logic          closed_r, closed_nxt;
  logic          timeout_r, timeout_nxt;
  logic          drive_r, drive_nxt;

  always_comb begin
    slc_pkg::cnt_t cnt_dec;
    slc_pkg::time_t load_time;
    cnt_dec       = countdown_r - slc_pkg::cnt_t'(1);
    load_time     = (item.on_time == '0) ? default_on_time : item.on_time;
    countdown_nxt = countdown_r;
    debounce_nxt  = debounce_r;
    pending_nxt   = pending_r;
    locked_nxt    = locked_r;
    opened_nxt    = opened_r;
    closed_nxt    = closed_r;
    timeout_nxt   = timeout_r;
    drive_nxt     = drive_r;
    case (item.mode)
      slc_pkg::MODE_TICK: begin
        if (countdown_r != '0) begin
          countdown_nxt = cnt_dec;
          drive_nxt     = 1'b1;
          if (item.feedback) begin
            debounce_nxt = '0;
            // Still latched as the count runs out: give up with a timeout.
            if (cnt_dec <= slc_pkg::cnt_t'(1)) begin
              {pending_nxt, locked_nxt, opened_nxt, closed_nxt, timeout_nxt} = 5'b10011;
              countdown_nxt = '0;
              drive_nxt     = 1'b0;
            end
          end else begin
            debounce_nxt = debounce_r + 3'd1;
            if (debounce_r >= 3'(slc_pkg::DEBOUNCE_LIMIT)) begin
              debounce_nxt  = '0;
              {pending_nxt, locked_nxt, opened_nxt, closed_nxt, timeout_nxt} = 5'b10100;
              countdown_nxt = '0;
              drive_nxt     = 1'b0;
            end
          end
        end else begin
          drive_nxt = 1'b0;
          // Idle: flag a drawer closing or a forced opening once.
          if (!pending_r) begin
            if (item.feedback && !closed_r) begin
              {pending_nxt, locked_nxt, opened_nxt, closed_nxt, timeout_nxt} = 5'b11010;
            end else if (!item.feedback && closed_r) begin
              {pending_nxt, locked_nxt, opened_nxt, closed_nxt, timeout_nxt} = 5'b10100;
            end
          end
        end
      end
      slc_pkg::MODE_OPEN: begin
        countdown_nxt = slc_pkg::cnt_t'(load_time);
      end
      slc_pkg::MODE_RELEASE: begin
        countdown_nxt = '0;
      end
      default: begin
        countdown_nxt = countdown_r;
      end
    endcase
  end

  always_comb begin
    result.drive  = drive_nxt;
    result.status = pending_nxt ?
                    {timeout_nxt, closed_nxt, opened_nxt, locked_nxt, 1'b1} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      countdown_r <= slc_pkg::cnt_t'(slc_pkg::RESET_COUNTDOWN);
      debounce_r  <= '0;
      pending_r   <= 1'b0;
      locked_r    <= 1'b0;
      opened_r    <= 1'b0;
      closed_r    <= 1'b0;
      timeout_r   <= 1'b0;
      drive_r     <= 1'b0;
    end else if (item_valid) begin
      countdown_r <= countdown_nxt;
      debounce_r  <= debounce_nxt;
      pending_r   <= pending_nxt;
      locked_r    <= locked_nxt;
      opened_r    <= opened_nxt;
      closed_r    <= closed_nxt;
      timeout_r   <= timeout_nxt;
      drive_r     <= drive_nxt;
    end
  end

  `SLC_ASSERT_NEXT(a_pending_sticky, pending_r, pending_r)
  `SLC_ASSERT_NOW(a_timeout_means_closed, timeout_r, closed_r && pending_r)
  `SLC_ASSERT_NOW(a_locked_means_closed, locked_r, closed_r && !opened_r)

endmodule

`default_nettype wire

[rtl/solenoid_lock_controller_unit.sv]
// Top level of the solenoid drawer-lock controller.
//
//   Channel   Direction  Handshake          Contents
//   in_ch     input      valid/ready        mode, feedback, on_time
//   out_ch    output     valid/ready        drive, status
//   cfg_*     input      write enable only  default_on_time
//
// One item per cycle is accepted while ready; its result is registered.
// A two-entry output buffer (result register plus skid register) lets an
// item enter while the previous result waits; in_ch.ready drops only when
// both are full. Reset is synchronous; it loads the drive countdown with 50
// and default_on_time with 50.
`default_nettype none
`include "solenoid_lock_controller_unit_assert.svh"

module solenoid_lock_controller_unit (
  input  wire logic           clk,
  input  wire logic           rst_n,
  slc_in_if.sink              in_ch,
  slc_out_if.source           out_ch,
  input  wire logic           cfg_we,
  input  wire slc_pkg::time_t cfg_wdata
);

  slc_pkg::time_t   default_on_time_r;
  slc_pkg::item_t   item;
  slc_pkg::result_t result;

  logic             in_acc;
  logic             out_take;
  logic             out_valid_r, out_valid_nxt;
  logic             skid_valid_r, skid_valid_nxt;
  slc_pkg::result_t out_data_r, out_data_nxt;
  slc_pkg::result_t skid_data_r, skid_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_on_time_r <= slc_pkg::time_t'(slc_pkg::DEFAULT_ON_RESET);
    end else if (cfg_we) begin
      default_on_time_r <= cfg_wdata;
    end
  end

  assign in_ch.ready = !skid_valid_r;
  assign in_acc      = in_ch.valid && !skid_valid_r;
  assign out_take    = out_valid_r && out_ch.ready;

  assign item.mode     = in_ch.mode;
  assign item.feedback = in_ch.feedback;
  assign item.on_time  = in_ch.on_time;

  slc_core u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .item_valid      (in_acc),
    .item            (item),
    .default_on_time (default_on_time_r),
    .result          (result)
  );

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = result;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_data_nxt  = result;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.drive  = out_data_r.drive;
  assign out_ch.status = out_data_r.status;

  `SLC_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r)
  `SLC_ASSERT_NEXT(a_stall_fills_skid, in_acc && out_valid_r && !out_ch.ready, skid_valid_r)
  `SLC_ASSERT_NOW(a_status_flagged, out_valid_r && (out_data_r.status != '0),
                  out_data_r.status[0])

endmodule

`default_nettype wire
